// ===== rtl/dq_pkg.sv =====
// Shared types and constants for the double-ended queue.
// Request and status codes and the fixed field widths; no dependencies.
`default_nettype none

package dq_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/dq_ram.sv =====
// Entry store of the double-ended queue: one write port, one read port with
// registered read data. Depends on dq_pkg for the entry width.
`default_nettype none

module dq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [dq_pkg::VALUE_W-1:0]  wdata,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               raddr,
  output logic      [dq_pkg::VALUE_W-1:0]  rdata
);

  logic [dq_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit values kept in a ring of DEPTH entries.
// Each input transaction is a request (tuser: 0 push front, 1 push back,
// 2 pop front, 3 pop back) with the value to push in tdata. Every request
// gives exactly one output transaction: the popped value (zero on pushes and
// errors), the entry count afterwards and a status in tuser (0 ok, 1 pop from
// an empty queue, 2 push into a full queue). Errors leave the queue unchanged.
// Throughput is one transaction per cycle while results are taken; the result
// appears in the cycle after the request is accepted, as the entry memory
// registers its read data. A single output register parts the two sides: a new
// request is taken whenever that register is empty or is being emptied in the
// same cycle. Depends on dq_pkg and dq_ram.
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] push_value
  input  wire logic [1:0]  s_tuser,   // [1:0] req_type
  // result channel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // [31:0] pop_value, [36:32] count_after, zero fill
  output logic      [1:0]  m_tuser    // [1:0] status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Queue state: ring position of the front entry and number held.
  logic [AW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;

  // Output register.
  logic                   out_valid;
  dq_pkg::status_t        out_status;
  logic [CW-1:0]          out_count;
  logic                   out_pop;

  logic [dq_pkg::VALUE_W-1:0] rdata;

  logic            accept;
  dq_pkg::req_t    req;
  dq_pkg::status_t status;
  logic            full, empty;
  logic [AW-1:0]   front_dec, front_inc, back_pos, last_pos;
  logic [CW:0]     back_sum, last_sum;
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [CW+4:0]   count_ext;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign req      = dq_pkg::req_t'(s_tuser);

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);

  // Ring neighbors of the front entry.
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;
  assign front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + 1'b1;

  // Slot after the back entry and the back entry itself; the sums stay below
  // twice the depth, so one conditional subtract wraps them.
  always_comb begin
    back_sum = (CW+1)'(front) + (CW+1)'(count);
    if (back_sum >= (CW+1)'(DEPTH)) begin
      back_sum = back_sum - (CW+1)'(DEPTH);
    end
    last_sum = (CW+1)'(front) + (CW+1)'(count) - 1'b1;
    if (last_sum >= (CW+1)'(DEPTH)) begin
      last_sum = last_sum - (CW+1)'(DEPTH);
    end
  end
  assign back_pos = back_sum[AW-1:0];
  assign last_pos = last_sum[AW-1:0];

  // Decode the request: memory access, status and next pointer/count.
  always_comb begin
    we         = 1'b0;
    re         = 1'b0;
    waddr      = back_pos;
    raddr      = front;
    status     = dq_pkg::ST_OK;
    front_next = front;
    count_next = count;
    unique case (req)
      dq_pkg::REQ_PUSH_FRONT: begin
        if (full) begin
          status = dq_pkg::ST_FULL;
        end else begin
          we         = accept;
          waddr      = front_dec;
          front_next = front_dec;
          count_next = count + 1'b1;
        end
      end
      dq_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          status = dq_pkg::ST_FULL;
        end else begin
          we         = accept;
          waddr      = back_pos;
          count_next = count + 1'b1;
        end
      end
      dq_pkg::REQ_POP_FRONT: begin
        if (empty) begin
          status = dq_pkg::ST_EMPTY;
        end else begin
          re         = accept;
          raddr      = front;
          front_next = front_inc;
          count_next = count - 1'b1;
        end
      end
      dq_pkg::REQ_POP_BACK: begin
        if (empty) begin
          status = dq_pkg::ST_EMPTY;
        end else begin
          re         = accept;
          raddr      = last_pos;
          count_next = count - 1'b1;
        end
      end
      default: begin
        status = dq_pkg::ST_OK;
      end
    endcase
  end

  // Pointer and count advance at acceptance; the next request already sees
  // them, and a write lands in memory before any later read of that entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (accept) begin
      front <= front_next;
      count <= count_next;
    end
  end

  dq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (s_tdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Output register: load on acceptance, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status;
      out_count  <= count_next;
      out_pop    <= re;
    end
  end

  // count_after carries the low five bits of the count.
  assign count_ext = {5'b0, out_count};

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, count_ext[dq_pkg::COUNT_W-1:0],
                     out_pop ? rdata : {dq_pkg::VALUE_W{1'b0}}};
  assign m_tuser  = out_status;

endmodule

`default_nettype wire
